// File: src/frame_encoder_stuffing_checksum_core_assert.svh
// Assertion macros for the checker file.
`ifndef FRAME_ENCODER_STUFFING_CHECKSUM_CORE_ASSERT_SVH
`define FRAME_ENCODER_STUFFING_CHECKSUM_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define FESC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define FESC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/fesc_pkg.sv
`default_nettype none

package fesc_pkg;

  // Default depth of the command queue between front and back
  localparam int unsigned CmdDepthDef = 4;

  // Framing bytes
  localparam logic [7:0] NetSync  = 8'hFF;
  localparam logic [7:0] NetZero  = 8'h00;
  localparam logic [7:0] SerStart = 8'hA5;
  localparam logic [7:0] SerEnd   = 8'hAE;
  localparam logic [7:0] SerEsc   = 8'hAA;
  localparam logic [7:0] EscOfEsc = 8'h0A;
  localparam logic [7:0] EscOfSta = 8'h05;
  localparam logic [7:0] EscOfEnd = 8'h0E;

  // Link modes
  localparam logic ModeNet    = 1'b0;
  localparam logic ModeSerial = 1'b1;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] payload_count;
  } fesc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } fesc_out_t;

  // One classified input item, as handed from front to back
  typedef struct packed {
    logic        serial;
    logic        first;
    logic        last;
    logic [7:0]  data;
    logic [15:0] frame_len;
    logic [15:0] csum;
  } fesc_cmd_t;

  function automatic logic needs_esc(input logic [7:0] b);
    needs_esc = (b == SerEsc) || (b == SerStart) || (b == SerEnd);
  endfunction

  function automatic logic [7:0] esc_code(input logic [7:0] b);
    if (b == SerEsc) begin
      esc_code = EscOfEsc;
    end else if (b == SerStart) begin
      esc_code = EscOfSta;
    end else begin
      esc_code = EscOfEnd;
    end
  endfunction

endpackage

`default_nettype wire

// File: src/fesc_cmd_queue.sv
`default_nettype none

module fesc_cmd_queue import fesc_pkg::*; #(
  parameter int unsigned Depth = CmdDepthDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire fesc_cmd_t cmd_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output fesc_cmd_t      cmd_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  fesc_cmd_t         slot_q [Depth];
  logic [AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CW'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the request payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: src/fesc_front.sv
`default_nettype none

module fesc_front import fesc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire fesc_in_t item_i,
  input  wire logic     q_full_i,
  input  wire logic     cfg_valid_i,
  input  wire logic     cfg_data_i,
  output logic          cmd_push_o,
  output fesc_cmd_t     cmd_o
);

  logic        mode_q;
  logic [15:0] sum_q, sum_d;
  logic [15:0] sum_base, sum_add;
  logic        accept;

  assign accept = push_i && !q_full_i;

  // Running sum: clear on a first byte, add, clear again after a last byte
  always_comb begin
    sum_base = item_i.first_byte ? 16'd0 : sum_q;
    sum_add  = sum_base + {8'd0, item_i.data_byte};
    sum_d    = sum_q;
    if (accept) begin
      sum_d = item_i.last_byte ? 16'd0 : sum_add;
    end
  end

  // Classify the request for the back part
  always_comb begin
    cmd_o.serial    = (mode_q == ModeSerial);
    cmd_o.first     = item_i.first_byte;
    cmd_o.last      = item_i.last_byte;
    cmd_o.data      = item_i.data_byte;
    cmd_o.frame_len = item_i.payload_count + 16'd2;
    cmd_o.csum      = sum_add;
  end

  assign cmd_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNet;
      sum_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      sum_q <= sum_d;
    end
  end

endmodule

`default_nettype wire

// File: src/fesc_back.sv
`default_nettype none

module fesc_back import fesc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cmd_valid_i,
  input  wire fesc_cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           empty_o,
  input  wire logic      pop_i,
  output fesc_out_t      res_o
);

  typedef enum logic [2:0] {
    PhStart,
    PhHdr,
    PhPay,
    PhCsLo,
    PhCsHi,
    PhEnd
  } phase_e;

  localparam logic [2:0] HdrLastIdx = 3'd7;
  localparam logic [2:0] HdrLenLo   = 3'd4;
  localparam logic [2:0] HdrLenHi   = 3'd5;

  phase_e      phase_q, cur_ph, nxt_ph, after_ph;
  logic [2:0]  idx_q, idx_d;
  logic        esc_q, esc_d;
  logic        rvalid_q;
  fesc_out_t   res_q;
  logic [7:0]  byte_d, raw;
  logic        end_d, end_after, stuff;
  logic        can_load, step, done;

  assign can_load = !rvalid_q || pop_i;
  assign step     = cmd_valid_i && can_load;

  // Pick the next output byte of the head request
  always_comb begin
    cur_ph    = (phase_q == PhStart) ? (cmd_i.first ? PhHdr : PhPay) : phase_q;
    nxt_ph    = cur_ph;
    after_ph  = PhStart;
    idx_d     = idx_q;
    esc_d     = esc_q;
    byte_d    = NetZero;
    end_d     = 1'b0;
    end_after = 1'b0;
    raw       = cmd_i.data;
    stuff     = 1'b0;

    unique case (cur_ph)
      PhHdr: begin
        if (cmd_i.serial) begin
          byte_d = SerStart;
          nxt_ph = PhPay;
        end else begin
          if (idx_q < HdrLenLo) begin
            byte_d = NetSync;
          end else if (idx_q == HdrLenLo) begin
            byte_d = cmd_i.frame_len[7:0];
          end else if (idx_q == HdrLenHi) begin
            byte_d = cmd_i.frame_len[15:8];
          end else begin
            byte_d = NetZero;
          end
          if (idx_q == HdrLastIdx) begin
            idx_d  = '0;
            nxt_ph = PhPay;
          end else begin
            idx_d  = idx_q + 1'b1;
          end
        end
      end
      PhPay: begin
        raw      = cmd_i.data;
        stuff    = 1'b1;
        after_ph = cmd_i.last ? PhCsLo : PhStart;
      end
      PhCsLo: begin
        raw      = cmd_i.csum[7:0];
        stuff    = 1'b1;
        after_ph = PhCsHi;
      end
      PhCsHi: begin
        raw       = cmd_i.csum[15:8];
        stuff     = 1'b1;
        after_ph  = cmd_i.serial ? PhEnd : PhStart;
        end_after = !cmd_i.serial;
      end
      PhEnd: begin
        byte_d = SerEnd;
        end_d  = 1'b1;
        nxt_ph = PhStart;
      end
      default: begin
        nxt_ph = PhStart;
      end
    endcase

    // Escape in two steps: escape byte first, then the code
    if (stuff) begin
      if (cmd_i.serial && needs_esc(raw) && !esc_q) begin
        byte_d = SerEsc;
        esc_d  = 1'b1;
        nxt_ph = cur_ph;
      end else begin
        byte_d = esc_q ? esc_code(raw) : raw;
        esc_d  = 1'b0;
        nxt_ph = after_ph;
        end_d  = end_after;
      end
    end

    done = (nxt_ph == PhStart);
  end

  assign cmd_pop_o = step && done;
  assign empty_o   = !rvalid_q;
  assign res_o     = res_q;

  // Hold sequencer state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhStart;
      idx_q    <= '0;
      esc_q    <= 1'b0;
      rvalid_q <= 1'b0;
      res_q    <= '0;
    end else begin
      if (step) begin
        phase_q        <= nxt_ph;
        idx_q          <= idx_d;
        esc_q          <= esc_d;
        rvalid_q       <= 1'b1;
        res_q.out_byte  <= byte_d;
        res_q.frame_end <= end_d;
      end else if (pop_i) begin
        rvalid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/frame_encoder_stuffing_checksum_core.sv
// Frame encoder with additive 16-bit checksum. Payload bytes are pushed one
// per request with first/last marks; results are popped one output byte per
// request, frame_end high on the last byte of a frame. link_mode (cfg port,
// write only while idle) picks network framing (FF FF FF FF, length + 2 low
// byte first, 00 00, payload, checksum low byte first) or serial framing
// (A5, stuffed payload and checksum, AE). The back sequencer emits exactly
// one output byte per cycle while a request is queued and the output
// register is free or being popped. Network frames add 8 header bytes and
// 2 checksum bytes; serial frames add 1 start byte and 3 to 5 trailer bytes,
// and an escaped byte goes out as two. The front accepts one byte per
// cycle into a CmdDepth-entry queue until it fills.
`default_nettype none

module frame_encoder_stuffing_checksum_core import fesc_pkg::*; #(
  parameter int unsigned CmdDepth = CmdDepthDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire fesc_in_t item_i,
  output logic          empty,
  input  wire logic     pop,
  output fesc_out_t     res_o,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire logic     cfg_data_i
);

  logic      cmd_push, cmd_pop, cmd_valid, q_full;
  fesc_cmd_t cmd_in, cmd_head;

  assign full        = q_full;
  assign cfg_ready_o = 1'b1;

  // Accept and classify
  fesc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (item_i),
    .q_full_i    (q_full),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  // Decouple front from back
  fesc_cmd_queue #(
    .Depth (CmdDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_head)
  );

  // Emit framed bytes
  fesc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// File: src/fesc_checker.sv
`default_nettype none

`include "frame_encoder_stuffing_checksum_core_assert.svh"

module fesc_checker import fesc_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      push,
  input wire logic      full,
  input wire fesc_in_t  item_i,
  input wire logic      empty,
  input wire logic      pop,
  input wire fesc_out_t res_o,
  input wire logic      cfg_valid_i,
  input wire logic      cfg_ready_o,
  input wire logic      cfg_data_i
);

  logic mode_q;

  // Track the link mode as written on the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNet;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  `FESC_ASSERT_NXT(a_res_hold, !empty && !pop, !empty && $stable(res_o), "result changed while stalled")

  `FESC_ASSERT_IMP(a_full_has_res, full, !empty, "queue full with no result waiting")

  `FESC_ASSERT_IMP(a_ser_end_byte, !empty && mode_q && res_o.frame_end, res_o.out_byte == SerEnd, "serial frame end is not the end byte")

  `FESC_ASSERT_IMP(a_ser_end_unique, !empty && mode_q && !res_o.frame_end, res_o.out_byte != SerEnd, "unescaped end byte inside serial frame")

endmodule

bind frame_encoder_stuffing_checksum_core fesc_checker u_fesc_checker (.*);

`default_nettype wire

// File: verif/testbench.sv
module testbench;
  import fesc_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int ItemTarget = 180;
  localparam int DirCount   = 24;

  // One directed request; typed_n > 0 means the framed bytes are spelled out
  typedef struct packed {
    logic            mode;
    fesc_in_t        item;
    logic [3:0]      typed_n;
    logic [0:10][7:0] typed;
  } dir_row_t;

  localparam dir_row_t DirRows [DirCount] = '{
    // network: single-byte frames at the extremes, length wrap and zero count
    '{ModeNet, '{8'h00, 1'b1, 1'b1, 16'h0001}, 4'd11,
      88'hFF_FF_FF_FF_03_00_00_00_00_00_00},
    '{ModeNet, '{8'hFF, 1'b1, 1'b1, 16'hFFFF}, 4'd11,
      88'hFF_FF_FF_FF_01_00_00_00_FF_FF_00},
    '{ModeNet, '{8'h80, 1'b1, 1'b1, 16'hFFFD}, 4'd11,
      88'hFF_FF_FF_FF_FF_FF_00_00_80_80_00},
    '{ModeNet, '{8'h55, 1'b1, 1'b1, 16'h0000}, 4'd11,
      88'hFF_FF_FF_FF_02_00_00_00_55_55_00},
    // network: three-byte frame
    '{ModeNet, '{8'h12, 1'b1, 1'b0, 16'h0003}, 4'd0, 88'h0},
    '{ModeNet, '{8'h34, 1'b0, 1'b0, 16'h0003}, 4'd0, 88'h0},
    '{ModeNet, '{8'h56, 1'b0, 1'b1, 16'h0003}, 4'd0, 88'h0},
    // bytes without a first mark, outside a frame
    '{ModeNet, '{8'h7F, 1'b0, 1'b0, 16'h8000}, 4'd0, 88'h0},
    '{ModeNet, '{8'h01, 1'b0, 1'b1, 16'h0000}, 4'd0, 88'h0},
    // abandoned frame, then a fresh one
    '{ModeNet, '{8'h10, 1'b1, 1'b0, 16'h0002}, 4'd0, 88'h0},
    '{ModeNet, '{8'h20, 1'b1, 1'b1, 16'h0001}, 4'd0, 88'h0},
    // frame opened in network mode, finished in serial mode
    '{ModeNet,    '{8'h99, 1'b1, 1'b0, 16'h0004}, 4'd0, 88'h0},
    '{ModeSerial, '{8'h42, 1'b0, 1'b0, 16'hFFFF}, 4'd0, 88'h0},
    '{ModeSerial, '{8'hAE, 1'b0, 1'b1, 16'h0000}, 4'd0, 88'h0},
    // serial: each escaped byte as payload and checksum
    '{ModeSerial, '{8'hAA, 1'b1, 1'b1, 16'hFFFF}, 4'd7,
      88'hA5_AA_0A_AA_0A_00_AE_00_00_00_00},
    '{ModeSerial, '{8'hA5, 1'b1, 1'b1, 16'h0000}, 4'd7,
      88'hA5_AA_05_AA_05_00_AE_00_00_00_00},
    '{ModeSerial, '{8'hAE, 1'b1, 1'b1, 16'h1234}, 4'd7,
      88'hA5_AA_0E_AA_0E_00_AE_00_00_00_00},
    '{ModeSerial, '{8'h01, 1'b1, 1'b0, 16'h0003}, 4'd0, 88'h0},
    '{ModeSerial, '{8'hA5, 1'b0, 1'b0, 16'h0003}, 4'd0, 88'h0},
    '{ModeSerial, '{8'hFF, 1'b0, 1'b1, 16'h0003}, 4'd0, 88'h0},
    // frame opened in serial mode, finished in network mode
    '{ModeSerial, '{8'h11, 1'b1, 1'b0, 16'h0002}, 4'd0, 88'h0},
    '{ModeNet,    '{8'h22, 1'b0, 1'b0, 16'h0002}, 4'd0, 88'h0},
    '{ModeNet,    '{8'h33, 1'b0, 1'b1, 16'h0002}, 4'd0, 88'h0},
    '{ModeSerial, '{8'h00, 1'b1, 1'b1, 16'h0001}, 4'd0, 88'h0}
  };

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  fesc_in_t  item_i;
  logic      empty;
  logic      pop;
  fesc_out_t res_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic      cfg_data_i;

  // Predictor state and the framed bytes still owed by the block
  logic        link_serial;
  logic [15:0] frame_sum;
  fesc_out_t   framed_q [$];
  int          mismatches;
  int          items_sent;
  int          tx_calm;
  int          rx_calm;
  int          cycle_count;

  frame_encoder_stuffing_checksum_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Idle cycles before a request; calm stretches force back-to-back traffic
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) calm = $urandom_range(5, 30);
    return $urandom_range(0, 16);
  endfunction

  function automatic void put_byte(input logic [7:0] b, input logic fin);
    fesc_out_t r;
    r.out_byte  = b;
    r.frame_end = fin;
    framed_q.insert(framed_q.size(), r);
  endfunction

  // Escape the three reserved serial bytes
  function automatic void put_stuffed(input logic [7:0] b);
    if (b == SerEsc) begin
      put_byte(SerEsc, 1'b0);
      put_byte(EscOfEsc, 1'b0);
    end else if (b == SerStart) begin
      put_byte(SerEsc, 1'b0);
      put_byte(EscOfSta, 1'b0);
    end else if (b == SerEnd) begin
      put_byte(SerEsc, 1'b0);
      put_byte(EscOfEnd, 1'b0);
    end else begin
      put_byte(b, 1'b0);
    end
  endfunction

  // Append the framed bytes caused by one accepted payload byte
  function automatic void encode_byte(input fesc_in_t it);
    logic [15:0] len;
    if (it.first_byte) begin
      frame_sum = '0;
      if (link_serial == ModeSerial) begin
        put_byte(SerStart, 1'b0);
      end else begin
        len = it.payload_count + 16'd2;
        repeat (4) put_byte(NetSync, 1'b0);
        put_byte(len[7:0], 1'b0);
        put_byte(len[15:8], 1'b0);
        put_byte(NetZero, 1'b0);
        put_byte(NetZero, 1'b0);
      end
    end
    frame_sum = frame_sum + {8'h00, it.data_byte};
    if (link_serial == ModeSerial) put_stuffed(it.data_byte);
    else put_byte(it.data_byte, 1'b0);
    if (it.last_byte) begin
      if (link_serial == ModeSerial) begin
        put_stuffed(frame_sum[7:0]);
        put_stuffed(frame_sum[15:8]);
        put_byte(SerEnd, 1'b1);
      end else begin
        put_byte(frame_sum[7:0], 1'b0);
        put_byte(frame_sum[15:8], 1'b1);
      end
      frame_sum = '0;
    end
  endfunction

  // Push one request; typed bytes, when given, replace the predicted ones
  task automatic send_item(input fesc_in_t it, input logic [3:0] typed_n,
                           input logic [0:10][7:0] typed);
    int gap;
    int base;
    gap = draw_gap(tx_calm);
    repeat (gap) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push   <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    base = framed_q.size();
    encode_byte(it);
    if (typed_n != 0) begin
      while (framed_q.size() > base) void'(framed_q.pop_back());
      for (int k = 0; k < typed_n; k++) put_byte(typed[k], k == typed_n - 1);
    end
    items_sent++;
  endtask

  // Hold off until every owed byte has come out, then let the pipe settle
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic mode);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    link_serial = mode;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Favor the reserved serial bytes so stuffing is hit often
  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 7))
      0: return SerEsc;
      1: return SerStart;
      2: return SerEnd;
      default: return 8'($urandom);
    endcase
  endfunction

  // Send a frame of random content; optionally leave it open or flip mode inside
  task automatic send_frame(input int len, input bit close, input bit flip);
    fesc_in_t it;
    for (int i = 0; i < len; i++) begin
      if (flip && i == len / 2 && i != 0) set_mode(~link_serial);
      it.data_byte     = pick_data();
      it.first_byte    = (i == 0);
      it.last_byte     = close && (i == len - 1);
      it.payload_count = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(len);
      send_item(it, 4'd0, 88'h0);
    end
  endtask

  // Result side: pop with random stalls and check against the oldest owed byte
  initial begin
    fesc_out_t want;
    fesc_out_t got;
    int gap;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(rx_calm);
      repeat (gap) begin
        @(negedge clk_i);
        pop <= 1'b0;
      end
      @(negedge clk_i);
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      got = res_o;
      if (framed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte %02h end %0b", got.out_byte, got.frame_end);
      end else begin
        want = framed_q.pop_front();
        if (got.out_byte != want.out_byte || got.frame_end != want.frame_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected byte %02h end %0b, got byte %02h end %0b",
                     want.out_byte, want.frame_end, got.out_byte, got.frame_end);
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("frame_encoder_stuffing_checksum_core regression: fail");
    $finish;
  end

  // Stimulus
  initial begin
    int kind;
    rst_ni      = 1'b0;
    push        = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    link_serial = ModeNet;
    frame_sum   = '0;
    mismatches  = 0;
    items_sent  = 0;
    tx_calm     = 0;
    rx_calm     = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table, switching mode only while idle
    for (int r = 0; r < DirCount; r++) begin
      if (DirRows[r].mode != link_serial) set_mode(DirRows[r].mode);
      send_item(DirRows[r].item, DirRows[r].typed_n, DirRows[r].typed);
    end

    // Random frames: mostly well formed, some noise, abandoned and mixed-mode
    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 3) == 0) set_mode(1'($urandom));
      kind = $urandom_range(0, 9);
      if (kind == 0) send_item(fesc_in_t'(26'($urandom)), 4'd0, 88'h0);
      else if (kind == 1) send_frame($urandom_range(1, 4), 1'b0, 1'b0);
      else if (kind == 2) send_frame($urandom_range(2, 6), 1'b1, 1'b1);
      else send_frame($urandom_range(1, 8), 1'b1, 1'b0);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && framed_q.size() == 0) begin
      $display("frame_encoder_stuffing_checksum_core regression: pass");
    end else begin
      $display("frame_encoder_stuffing_checksum_core regression: fail");
    end
    $finish;
  end

endmodule
